// File: rtl/dprv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprv_pkg
// Shared types, codes and CRC helpers for the dual page record validator.
// ----------------------------------------------------------------------------
package dprv_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_MAGIC       = 3'd0,
        CFG_CUR_VERSION = 3'd1,
        CFG_LEG_VERSION = 3'd2,
        CFG_CUR_PAYLOAD = 3'd3,
        CFG_LEG_PAYLOAD = 3'd4,
        CFG_CUR_CRC_OFF = 3'd5,
        CFG_LEG_CRC_OFF = 3'd6
    } t_cfg_idx;

    typedef logic [1:0] t_fmt;
    localparam t_fmt FMT_INVALID = 2'd0;
    localparam t_fmt FMT_LEGACY  = 2'd1;
    localparam t_fmt FMT_CURRENT = 2'd2;

    typedef logic [1:0] t_sel;
    localparam t_sel SEL_NONE   = 2'd0;
    localparam t_sel SEL_FIRST  = 2'd1;
    localparam t_sel SEL_SECOND = 2'd2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [31:0] RST_MAGIC       = 32'h5241_4449;
    localparam logic [15:0] RST_CUR_VERSION = 16'd3;
    localparam logic [15:0] RST_LEG_VERSION = 16'd2;
    localparam logic [9:0]  RST_CUR_PAYLOAD = 10'd48;
    localparam logic [9:0]  RST_LEG_PAYLOAD = 10'd32;
    localparam logic [9:0]  RST_CUR_CRC_OFF = 10'd60;
    localparam logic [9:0]  RST_LEG_CRC_OFF = 10'd44;

    // Header length in bytes (fixed layout)
    localparam int HDR_BYTES = 12;

    // Reflected CRC-32, one byte, eight shift steps unrolled
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Replace byte lane 'lane' of a 32-bit word
    function automatic logic [31:0] put_lane(input logic [31:0] w,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
        logic [31:0] r;
        r = w;
        r[lane*8 +: 8] = b;
        return r;
    endfunction

endpackage

// File: rtl/dual_page_record_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_page_record_validator
// Parses and CRC-checks a record streamed byte by byte from one of two flash
// pages, judges each finished page and selects the page with newer sequence.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload                          Dir
//  -------   ------------------   ------------------------------   ---
//  byte in   i_valid / o_ready    i_page, i_data_byte, i_last_byte  in
//  result    o_valid / i_ready    o_page_*, o_selected_*            out
//  config    i_cfg_we (no wait)   i_cfg_idx, i_cfg_data             in
//
//  One byte request is taken per cycle while o_ready is high; the CRC byte
//  update and header capture happen at the accept edge.
//  A last-byte request is judged into the judge register at its accept edge,
//  and moves on into the output register once that is free or draining.
//  Bytes without the last mark produce no result, but they wait like any
//  other request while o_ready is low.
//  o_ready drops only when the judge register and output register are both
//  full and the output is stalled.
//  Reset (i_rst_n low, synchronous) restores registers, parser and verdicts.
//
module dual_page_record_validator #(
    parameter int PAGE_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_page,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_page_good,
    output logic [1:0]  o_page_format,
    output logic [31:0] o_page_sequence,
    output logic [1:0]  o_selected_page,
    output logic [1:0]  o_selected_format,
    output logic [31:0] o_selected_sequence,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Offset counter saturates at PAGE_BYTES, so it needs one value more
    localparam int OW = $clog2(PAGE_BYTES + 1);
    // Compare width: holds the counter and a CRC offset plus four
    localparam int CW = (OW > 11) ? OW : 11;
    localparam logic [OW-1:0] PAGE_LIMIT = OW'(PAGE_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_magic;
    logic [15:0] r_cur_ver, r_leg_ver;
    logic [9:0]  r_cur_pay, r_leg_pay, r_cur_off, r_leg_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= dprv_pkg::RST_MAGIC;
            r_cur_ver <= dprv_pkg::RST_CUR_VERSION;
            r_leg_ver <= dprv_pkg::RST_LEG_VERSION;
            r_cur_pay <= dprv_pkg::RST_CUR_PAYLOAD;
            r_leg_pay <= dprv_pkg::RST_LEG_PAYLOAD;
            r_cur_off <= dprv_pkg::RST_CUR_CRC_OFF;
            r_leg_off <= dprv_pkg::RST_LEG_CRC_OFF;
        end else if (i_cfg_we) begin
            unique case (dprv_pkg::t_cfg_idx'(i_cfg_idx))
                dprv_pkg::CFG_MAGIC:       r_magic   <= i_cfg_data;
                dprv_pkg::CFG_CUR_VERSION: r_cur_ver <= i_cfg_data[15:0];
                dprv_pkg::CFG_LEG_VERSION: r_leg_ver <= i_cfg_data[15:0];
                dprv_pkg::CFG_CUR_PAYLOAD: r_cur_pay <= i_cfg_data[9:0];
                dprv_pkg::CFG_LEG_PAYLOAD: r_leg_pay <= i_cfg_data[9:0];
                dprv_pkg::CFG_CUR_CRC_OFF: r_cur_off <= i_cfg_data[9:0];
                dprv_pkg::CFG_LEG_CRC_OFF: r_leg_off <= i_cfg_data[9:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic r_j_vld, r_o_vld;
    logic j_adv, in_acc;

    // Judge register moves on when the output register is free or draining
    assign j_adv   = r_j_vld && (!r_o_vld || i_ready);
    assign o_ready = !r_j_vld || j_adv;
    assign in_acc  = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [OW-1:0] r_off;
    logic [31:0]   r_crc, r_magic_hdr, r_seq_hdr;
    logic [15:0]   r_ver_hdr, r_pay_hdr;
    logic [31:0]   r_crc_cur, r_crc_leg, r_st_cur, r_st_leg;

    logic [OW-1:0] u_off;
    logic [31:0]   u_crc, u_magic_hdr, u_seq_hdr;
    logic [15:0]   u_ver_hdr, u_pay_hdr;
    logic [31:0]   u_crc_cur, u_crc_leg, u_st_cur, u_st_leg;

    logic [CW-1:0] off_c, cur_base, leg_base, cur_end, leg_end;
    logic          in_range, cur_hit, leg_hit;
    logic [CW-1:0] cur_rel, leg_rel;

    always_comb begin
        in_range = r_off < PAGE_LIMIT;
        off_c    = CW'(r_off);
        cur_base = CW'(r_cur_off);
        leg_base = CW'(r_leg_off);
        cur_end  = cur_base + CW'(4);
        leg_end  = leg_base + CW'(4);
        cur_rel  = off_c - cur_base;
        leg_rel  = off_c - leg_base;
        cur_hit  = (off_c >= cur_base) && (off_c < cur_end);
        leg_hit  = (off_c >= leg_base) && (off_c < leg_end);

        // Hold by default; bytes past the page window only carry the last mark
        u_off       = r_off;
        u_crc       = r_crc;
        u_magic_hdr = r_magic_hdr;
        u_ver_hdr   = r_ver_hdr;
        u_pay_hdr   = r_pay_hdr;
        u_seq_hdr   = r_seq_hdr;
        u_crc_cur   = r_crc_cur;
        u_crc_leg   = r_crc_leg;
        u_st_cur    = r_st_cur;
        u_st_leg    = r_st_leg;

        if (in_range) begin
            // Snapshot the finished CRC just before the stored CRC word starts
            if (off_c == cur_base) u_crc_cur = ~r_crc;
            if (off_c == leg_base) u_crc_leg = ~r_crc;
            if (cur_hit) u_st_cur = dprv_pkg::put_lane(r_st_cur, cur_rel[1:0], i_data_byte);
            if (leg_hit) u_st_leg = dprv_pkg::put_lane(r_st_leg, leg_rel[1:0], i_data_byte);
            // Fixed header: magic, version, payload size, sequence
            if (off_c < CW'(dprv_pkg::HDR_BYTES)) begin
                unique case (r_off[3:2])
                    2'd0: u_magic_hdr = dprv_pkg::put_lane(r_magic_hdr, r_off[1:0],
                                                           i_data_byte);
                    2'd1: begin
                        if (r_off[1]) begin
                            u_pay_hdr[r_off[0]*8 +: 8] = i_data_byte;
                        end else begin
                            u_ver_hdr[r_off[0]*8 +: 8] = i_data_byte;
                        end
                    end
                    2'd2: u_seq_hdr = dprv_pkg::put_lane(r_seq_hdr, r_off[1:0],
                                                         i_data_byte);
                    default: ;
                endcase
            end
            u_crc = dprv_pkg::crc32_byte(r_crc, i_data_byte);
            u_off = r_off + OW'(1);
        end
    end

    // Judge the page from the updated parser values
    logic         cur_ok, leg_ok;
    dprv_pkg::t_fmt j_fmt;

    always_comb begin
        cur_ok = (u_magic_hdr == r_magic) && (u_ver_hdr == r_cur_ver)
              && (u_pay_hdr == 16'(r_cur_pay)) && (CW'(u_off) >= cur_end)
              && (u_crc_cur == u_st_cur);
        leg_ok = (u_magic_hdr == r_magic) && (u_ver_hdr == r_leg_ver)
              && (u_pay_hdr == 16'(r_leg_pay)) && (CW'(u_off) >= leg_end)
              && (u_crc_leg == u_st_leg);
        priority if (cur_ok) begin
            j_fmt = dprv_pkg::FMT_CURRENT;
        end else if (leg_ok) begin
            j_fmt = dprv_pkg::FMT_LEGACY;
        end else begin
            j_fmt = dprv_pkg::FMT_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last_byte)) begin
            // Reset or last byte: return the parser to its idle state
            r_off       <= '0;
            r_crc       <= dprv_pkg::CRC_INIT;
            r_magic_hdr <= '0;
            r_ver_hdr   <= '0;
            r_pay_hdr   <= '0;
            r_seq_hdr   <= '0;
            r_crc_cur   <= '0;
            r_crc_leg   <= '0;
            r_st_cur    <= '0;
            r_st_leg    <= '0;
        end else if (in_acc) begin
            r_off       <= u_off;
            r_crc       <= u_crc;
            r_magic_hdr <= u_magic_hdr;
            r_ver_hdr   <= u_ver_hdr;
            r_pay_hdr   <= u_pay_hdr;
            r_seq_hdr   <= u_seq_hdr;
            r_crc_cur   <= u_crc_cur;
            r_crc_leg   <= u_crc_leg;
            r_st_cur    <= u_st_cur;
            r_st_leg    <= u_st_leg;
        end
    end

    // ------------------------------------------------------------------
    // Judge register
    // ------------------------------------------------------------------
    dprv_pkg::t_fmt r_j_fmt;
    logic [31:0]    r_j_seq;
    logic           r_j_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_j_vld <= 1'b1;
        end else if (j_adv) begin
            r_j_vld <= 1'b0;
        end
        if (in_acc && i_last_byte) begin
            r_j_fmt  <= j_fmt;
            r_j_seq  <= (j_fmt != dprv_pkg::FMT_INVALID) ? u_seq_hdr : 32'd0;
            r_j_page <= i_page;
        end
    end

    // ------------------------------------------------------------------
    // Verdicts and page selection
    // ------------------------------------------------------------------
    dprv_pkg::t_fmt r_vf [2];
    logic [31:0]    r_vs [2];

    dprv_pkg::t_fmt m_fmt0, m_fmt1;
    logic [31:0]    m_seq0, m_seq1, seq_diff;
    logic           va, vb, first_newer;
    dprv_pkg::t_sel sel;
    dprv_pkg::t_fmt sel_fmt;
    logic [31:0]    sel_seq;

    always_comb begin
        // Merge the fresh verdict into the stored pair
        m_fmt0 = r_j_page ? r_vf[0] : r_j_fmt;
        m_seq0 = r_j_page ? r_vs[0] : r_j_seq;
        m_fmt1 = r_j_page ? r_j_fmt : r_vf[1];
        m_seq1 = r_j_page ? r_j_seq : r_vs[1];
        va = m_fmt0 != dprv_pkg::FMT_INVALID;
        vb = m_fmt1 != dprv_pkg::FMT_INVALID;
        // Serial-number compare: first is newer when the difference is positive
        seq_diff    = m_seq0 - m_seq1;
        first_newer = (seq_diff != 32'd0) && !seq_diff[31];
        priority if (va && vb) begin
            sel = first_newer ? dprv_pkg::SEL_FIRST : dprv_pkg::SEL_SECOND;
        end else if (va) begin
            sel = dprv_pkg::SEL_FIRST;
        end else if (vb) begin
            sel = dprv_pkg::SEL_SECOND;
        end else begin
            sel = dprv_pkg::SEL_NONE;
        end
        unique case (sel)
            dprv_pkg::SEL_FIRST: begin
                sel_fmt = m_fmt0;
                sel_seq = m_seq0;
            end
            dprv_pkg::SEL_SECOND: begin
                sel_fmt = m_fmt1;
                sel_seq = m_seq1;
            end
            default: begin
                sel_fmt = dprv_pkg::FMT_INVALID;
                sel_seq = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf[0] <= dprv_pkg::FMT_INVALID;
            r_vf[1] <= dprv_pkg::FMT_INVALID;
            r_vs[0] <= 32'd0;
            r_vs[1] <= 32'd0;
        end else if (j_adv) begin
            r_vf[0] <= m_fmt0;
            r_vf[1] <= m_fmt1;
            r_vs[0] <= m_seq0;
            r_vs[1] <= m_seq1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    dprv_pkg::t_fmt r_o_fmt, r_o_sfmt;
    logic [31:0]    r_o_seq, r_o_sseq;
    dprv_pkg::t_sel r_o_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (j_adv) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
        if (j_adv) begin
            r_o_fmt  <= r_j_fmt;
            r_o_seq  <= r_j_seq;
            r_o_sel  <= sel;
            r_o_sfmt <= sel_fmt;
            r_o_sseq <= sel_seq;
        end
    end

    assign o_valid             = r_o_vld;
    assign o_page_good         = r_o_fmt != dprv_pkg::FMT_INVALID;
    assign o_page_format       = r_o_fmt;
    assign o_page_sequence     = r_o_seq;
    assign o_selected_page     = r_o_sel;
    assign o_selected_format   = r_o_sfmt;
    assign o_selected_sequence = r_o_sseq;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An invalid page never reports a sequence
    a_invalid_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_page_good) |-> (o_page_sequence == 32'd0))
        else $error("invalid page carries a sequence");

    // No selection means zero format and sequence; a selection is never invalid
    a_sel_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_selected_page == dprv_pkg::SEL_NONE)) |->
        ((o_selected_format == dprv_pkg::FMT_INVALID) && (o_selected_sequence == 32'd0)))
        else $error("empty selection carries data");

    a_sel_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_selected_page != dprv_pkg::SEL_NONE)) |->
        (o_selected_format != dprv_pkg::FMT_INVALID))
        else $error("selected page has no valid format");

    // A valid finished page is always selectable
    a_valid_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_good) |-> (o_selected_page != dprv_pkg::SEL_NONE))
        else $error("valid page left nothing selected");

    // The parser restarts after every accepted last byte
    a_parser_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> (r_off == '0))
        else $error("parser not cleared after last byte");

endmodule

// File: bench/dual_page_record_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_page_record_validator_tb
// Streams records into both flash pages through the byte channel and checks
// every page verdict and page selection. A predictor in the bench tracks the
// header, CRC captures and both page verdicts, and queues the expected
// verdict for each last-byte request. Directed records cover the reset
// register values, sequence ordering, window limits, register extremes and
// one long receiver hold. Random records and noise then run under several
// register settings, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module dual_page_record_validator_tb;

    localparam int PAGE_BYTES   = 1024;
    // Settle margin after the last expected verdict is seen
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 80;
    localparam int PHASE_BYTES  = 40;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] cur_ver;
        logic [15:0] leg_ver;
        logic [9:0]  cur_pay;
        logic [9:0]  leg_pay;
        logic [9:0]  cur_off;
        logic [9:0]  leg_off;
    } t_cfg;

    typedef struct packed {
        logic           page_good;
        dprv_pkg::t_fmt page_format;
        logic [31:0]    page_sequence;
        dprv_pkg::t_sel selected_page;
        dprv_pkg::t_fmt selected_format;
        logic [31:0]    selected_sequence;
    } t_verdict;

    localparam t_cfg RESET_CFG = '{dprv_pkg::RST_MAGIC, dprv_pkg::RST_CUR_VERSION,
                                   dprv_pkg::RST_LEG_VERSION, dprv_pkg::RST_CUR_PAYLOAD,
                                   dprv_pkg::RST_LEG_PAYLOAD, dprv_pkg::RST_CUR_CRC_OFF,
                                   dprv_pkg::RST_LEG_CRC_OFF};

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_page;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_page_good;
    logic [1:0]  o_page_format;
    logic [31:0] o_page_sequence;
    logic [1:0]  o_selected_page;
    logic [1:0]  o_selected_format;
    logic [31:0] o_selected_sequence;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    // ------------------------------------------------------------------------
    // Predictor state: register copy, shared parser, per-page verdicts
    // ------------------------------------------------------------------------
    t_cfg           regs_now;
    logic [10:0]    rec_count;
    logic [31:0]    rec_crc;
    logic [31:0]    rec_magic;
    logic [15:0]    rec_ver;
    logic [15:0]    rec_pay;
    logic [31:0]    rec_seq;
    logic [31:0]    crc_seen_cur;
    logic [31:0]    crc_seen_leg;
    logic [31:0]    crc_stored_cur;
    logic [31:0]    crc_stored_leg;
    dprv_pkg::t_fmt page_fmt [2];
    logic [31:0]    page_seq [2];

    t_verdict    expected_verdicts[$];
    logic [7:0]  rec_bytes[$];
    logic [31:0] last_seq;

    int unsigned bytes_in;
    int unsigned failures;
    int unsigned cycle_count;
    bit          idle_en;
    int unsigned rx_hold_req;
    int unsigned rx_hold_left;
    int unsigned rx_burst_left;

    dual_page_record_validator #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_page              (i_page),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_page_good         (o_page_good),
        .o_page_format       (o_page_format),
        .o_page_sequence     (o_page_sequence),
        .o_selected_page     (o_selected_page),
        .o_selected_format   (o_selected_format),
        .o_selected_sequence (o_selected_sequence),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Give up if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Reflected CRC-32, one bit of the byte at a time, LSB first
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ dprv_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_parse();
        rec_count      = '0;
        rec_crc        = dprv_pkg::CRC_INIT;
        rec_magic      = '0;
        rec_ver        = '0;
        rec_pay        = '0;
        rec_seq        = '0;
        crc_seen_cur   = '0;
        crc_seen_leg   = '0;
        crc_stored_cur = '0;
        crc_stored_leg = '0;
    endfunction

    function automatic bit format_matches(input logic [15:0] ver, input logic [9:0] pay,
                                          input logic [9:0] off, input logic [31:0] seen,
                                          input logic [31:0] stored);
        // The whole stored CRC word must have arrived inside the window
        return rec_magic == regs_now.magic && rec_ver == ver && rec_pay == {6'd0, pay}
            && rec_count >= {1'b0, off} + 11'd4 && seen == stored;
    endfunction

    // Advance the parser by one byte request; on a last byte judge the page,
    // pick the newer valid page and queue the verdict
    function automatic void predict_byte(input logic pg, input logic [7:0] b, input logic lst);
        logic [10:0]    cur_rel;
        logic [10:0]    leg_rel;
        logic [31:0]    seq_diff;
        t_verdict       v;
        dprv_pkg::t_sel sel;
        cur_rel = rec_count - {1'b0, regs_now.cur_off};
        leg_rel = rec_count - {1'b0, regs_now.leg_off};
        // Bytes past the page size only count for their last mark
        if (rec_count < PAGE_BYTES) begin
            if (rec_count == {1'b0, regs_now.cur_off}) begin
                crc_seen_cur = ~rec_crc;
            end
            if (rec_count == {1'b0, regs_now.leg_off}) begin
                crc_seen_leg = ~rec_crc;
            end
            if (rec_count >= {1'b0, regs_now.cur_off} && cur_rel < 4) begin
                crc_stored_cur[cur_rel[1:0]*8 +: 8] = b;
            end
            if (rec_count >= {1'b0, regs_now.leg_off} && leg_rel < 4) begin
                crc_stored_leg[leg_rel[1:0]*8 +: 8] = b;
            end
            if (rec_count < 4) begin
                rec_magic[rec_count[1:0]*8 +: 8] = b;
            end else if (rec_count < 6) begin
                rec_ver[rec_count[0]*8 +: 8] = b;
            end else if (rec_count < 8) begin
                rec_pay[rec_count[0]*8 +: 8] = b;
            end else if (rec_count < 12) begin
                rec_seq[rec_count[1:0]*8 +: 8] = b;
            end
            rec_crc   = crc_step(rec_crc, b);
            rec_count = rec_count + 11'd1;
        end
        if (!lst) begin
            return;
        end

        // Current format wins over legacy when both fit
        v = '0;
        if (format_matches(regs_now.cur_ver, regs_now.cur_pay, regs_now.cur_off,
                           crc_seen_cur, crc_stored_cur)) begin
            v.page_format = dprv_pkg::FMT_CURRENT;
        end else if (format_matches(regs_now.leg_ver, regs_now.leg_pay, regs_now.leg_off,
                                    crc_seen_leg, crc_stored_leg)) begin
            v.page_format = dprv_pkg::FMT_LEGACY;
        end
        v.page_good = (v.page_format != dprv_pkg::FMT_INVALID);
        if (v.page_good) begin
            v.page_sequence = rec_seq;
        end
        page_fmt[pg] = v.page_format;
        page_seq[pg] = v.page_sequence;

        // Serial-number compare: first page wins only if strictly newer
        seq_diff = page_seq[0] - page_seq[1];
        if (page_fmt[0] != dprv_pkg::FMT_INVALID && page_fmt[1] != dprv_pkg::FMT_INVALID) begin
            sel = (seq_diff != 0 && !seq_diff[31]) ? dprv_pkg::SEL_FIRST : dprv_pkg::SEL_SECOND;
        end else if (page_fmt[0] != dprv_pkg::FMT_INVALID) begin
            sel = dprv_pkg::SEL_FIRST;
        end else if (page_fmt[1] != dprv_pkg::FMT_INVALID) begin
            sel = dprv_pkg::SEL_SECOND;
        end else begin
            sel = dprv_pkg::SEL_NONE;
        end
        v.selected_page = sel;
        if (sel == dprv_pkg::SEL_FIRST) begin
            v.selected_format   = page_fmt[0];
            v.selected_sequence = page_seq[0];
        end else if (sel == dprv_pkg::SEL_SECOND) begin
            v.selected_format   = page_fmt[1];
            v.selected_sequence = page_seq[1];
        end
        expected_verdicts.push_back(v);
        clear_parse();
    endfunction

    // Predict every accepted byte request, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            predict_byte(i_page, i_data_byte, i_last_byte);
            bytes_in++;
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result request with none expected: expected nothing actual %0h",
                         $time, o_page_sequence);
                failures++;
            end else begin
                want = expected_verdicts.pop_front();
                check_field("page_good", want.page_good, o_page_good);
                check_field("page_format", want.page_format, o_page_format);
                check_field("page_sequence", want.page_sequence, o_page_sequence);
                check_field("selected_page", want.selected_page, o_selected_page);
                check_field("selected_format", want.selected_format, o_selected_format);
                check_field("selected_sequence", want.selected_sequence, o_selected_sequence);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_burst_left != 0) begin
            rx_burst_left--;
            i_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            // start a random stall burst
            rx_burst_left = $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic pg, input logic [7:0] b, input logic lst);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_page      <= pg;
        i_data_byte <= b;
        i_last_byte <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Only the last byte's page matters, so scatter the page bit elsewhere
    task automatic send_record(input logic pg);
        for (int i = 0; i < rec_bytes.size(); i++) begin
            if (i == rec_bytes.size() - 1) begin
                send_byte(pg, rec_bytes[i], 1'b1);
            end else begin
                send_byte(1'($urandom), rec_bytes[i], 1'b0);
            end
        end
    endtask

    // Lay out header, random payload and a matching stored CRC word
    task automatic build_record(input bit as_cur, input logic [31:0] seq,
                                input int unsigned len);
        logic [95:0] header;
        logic [31:0] crc;
        logic [15:0] ver;
        logic [9:0]  pay;
        int unsigned off;
        off    = as_cur ? regs_now.cur_off : regs_now.leg_off;
        ver    = as_cur ? regs_now.cur_ver : regs_now.leg_ver;
        pay    = as_cur ? regs_now.cur_pay : regs_now.leg_pay;
        header = {seq, 6'd0, pay, ver, regs_now.magic};
        rec_bytes.delete();
        for (int i = 0; i < len; i++) begin
            rec_bytes.push_back(i < 12 ? header[i*8 +: 8] : 8'($urandom));
        end
        crc = dprv_pkg::CRC_INIT;
        for (int i = 0; i < off && i < len; i++) begin
            crc = crc_step(crc, rec_bytes[i]);
        end
        // An offset inside the header overwrites header bytes on purpose
        for (int i = 0; i < 4 && off + i < len; i++) begin
            rec_bytes[off + i] = ~crc[i*8 +: 8];
        end
    endtask

    // Exact-length record; spoil breaks the stored CRC
    task automatic send_full(input logic pg, input bit as_cur, input logic [31:0] seq,
                             input bit spoil);
        int unsigned off;
        off = as_cur ? regs_now.cur_off : regs_now.leg_off;
        build_record(as_cur, seq, off + 4);
        if (spoil) begin
            rec_bytes[off] ^= 8'h01;
        end
        send_record(pg);
    endtask

    // Drop valid, wait for every expected verdict, then let the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] cfg_word(input t_cfg c, input dprv_pkg::t_cfg_idx k);
        case (k)
            dprv_pkg::CFG_MAGIC:       return c.magic;
            dprv_pkg::CFG_CUR_VERSION: return {16'd0, c.cur_ver};
            dprv_pkg::CFG_LEG_VERSION: return {16'd0, c.leg_ver};
            dprv_pkg::CFG_CUR_PAYLOAD: return {22'd0, c.cur_pay};
            dprv_pkg::CFG_LEG_PAYLOAD: return {22'd0, c.leg_pay};
            dprv_pkg::CFG_CUR_CRC_OFF: return {22'd0, c.cur_off};
            dprv_pkg::CFG_LEG_CRC_OFF: return {22'd0, c.leg_off};
            default:                   return '0;
        endcase
    endfunction

    // Write all registers back to back; only while idle
    task automatic apply_cfg(input t_cfg c);
        for (int k = dprv_pkg::CFG_MAGIC; k <= dprv_pkg::CFG_LEG_CRC_OFF; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= cfg_word(c, dprv_pkg::t_cfg_idx'(k));
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        regs_now = c;
    endtask

    // Small offsets keep records short; formats sometimes overlap
    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.magic   = $urandom;
        c.cur_ver = 16'($urandom);
        c.leg_ver = ($urandom_range(0, 3) == 0) ? c.cur_ver : 16'($urandom);
        c.cur_pay = 10'($urandom_range(0, 1008));
        c.leg_pay = ($urandom_range(0, 3) == 0) ? c.cur_pay : 10'($urandom_range(0, 1008));
        c.cur_off = 10'($urandom_range(12, 40));
        c.leg_off = ($urandom_range(0, 3) == 0) ? c.cur_off : 10'($urandom_range(12, 40));
        return c;
    endfunction

    // One random window: mostly good records, some short, spoiled or noise
    task automatic random_window();
        int unsigned pick;
        int unsigned off;
        int unsigned len;
        int unsigned idx;
        bit          as_cur;
        logic [31:0] seq;
        pick   = $urandom_range(0, 19);
        as_cur = $urandom_range(0, 1);
        off    = as_cur ? regs_now.cur_off : regs_now.leg_off;
        // Keep sequences near the last one so the compare sees ties and wraps
        case ($urandom_range(0, 4))
            0:       seq = $urandom;
            1:       seq = last_seq;
            2:       seq = last_seq + 32'd1;
            3:       seq = last_seq - 32'd1;
            default: seq = last_seq ^ 32'h8000_0000;
        endcase
        last_seq = seq;
        if (pick < 2) begin
            rec_bytes.delete();
            repeat ($urandom_range(1, 24)) rec_bytes.push_back(8'($urandom));
            send_record(1'($urandom));
        end else if (pick < 3) begin
            // Unterminated fragment: misaligns the next record
            repeat ($urandom_range(1, 16)) send_byte(1'($urandom), 8'($urandom), 1'b0);
        end else begin
            len = (pick < 5) ? $urandom_range(1, off + 3) : off + 4 + $urandom_range(0, 4);
            build_record(as_cur, seq, len);
            if (pick >= 5 && pick < 8) begin
                idx = $urandom_range(0, len - 1);
                rec_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            send_record(1'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Registers still at reset values: current, legacy and a bad CRC
    task automatic test_reset_values();
        send_full(1'b0, 1'b1, 32'd5, 1'b0);
        send_full(1'b1, 1'b0, 32'd7, 1'b0);
        send_full(1'b1, 1'b1, 32'd9, 1'b1);
        wait_idle();
    endtask

    // Ties go to the second page; compare wraps; no valid page at all
    task automatic test_sequence_compare();
        apply_cfg('{magic: dprv_pkg::RST_MAGIC, cur_ver: dprv_pkg::RST_CUR_VERSION,
                    leg_ver: dprv_pkg::RST_LEG_VERSION, cur_pay: dprv_pkg::RST_CUR_PAYLOAD,
                    leg_pay: dprv_pkg::RST_LEG_PAYLOAD, cur_off: 10'd12, leg_off: 10'd16});
        send_full(1'b0, 1'b1, 32'd100, 1'b0);
        send_full(1'b1, 1'b1, 32'd100, 1'b0);
        send_full(1'b0, 1'b1, 32'h0000_0001, 1'b0);
        send_full(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_full(1'b0, 1'b0, 32'h8000_0000, 1'b0);
        send_full(1'b1, 1'b1, 32'h0000_0000, 1'b0);
        send_full(1'b0, 1'b1, 32'd3, 1'b1);
        send_full(1'b1, 1'b0, 32'd4, 1'b1);
        wait_idle();
    endtask

    // One-byte windows and a window one byte short
    task automatic test_window_limits();
        send_byte(1'b1, 8'hFF, 1'b1);
        send_byte(1'b0, 8'h00, 1'b1);
        build_record(1'b1, 32'd11, regs_now.cur_off + 3);
        send_record(1'b0);
        wait_idle();
    endtask

    // Register extremes, a window past the page size, an offset inside the
    // header, identical formats
    task automatic test_register_extremes();
        apply_cfg('{magic: 32'h0, cur_ver: 16'hFFFF, leg_ver: 16'h0, cur_pay: 10'd1008,
                    leg_pay: 10'd0, cur_off: 10'd1020, leg_off: 10'd12});
        // Stored CRC ends at the page size; the trailing bytes are ignored
        build_record(1'b1, 32'h1234_5678, PAGE_BYTES + 6);
        send_record(1'b1);
        send_full(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        wait_idle();
        // Current CRC word lands on the sequence field
        apply_cfg('{magic: 32'hFFFF_FFFF, cur_ver: 16'h0, leg_ver: 16'hFFFF, cur_pay: 10'd0,
                    leg_pay: 10'd1008, cur_off: 10'd8, leg_off: 10'd20});
        send_full(1'b1, 1'b1, 32'hA5A5_5A5A, 1'b0);
        send_full(1'b0, 1'b0, 32'h0000_0010, 1'b0);
        wait_idle();
        apply_cfg('{magic: dprv_pkg::RST_MAGIC, cur_ver: 16'd5, leg_ver: 16'd5, cur_pay: 10'd20,
                    leg_pay: 10'd20, cur_off: 10'd30, leg_off: 10'd30});
        send_full(1'b0, 1'b1, 32'd77, 1'b0);
        wait_idle();
    endtask

    // Hold the receiver long enough that the block fills and stalls input
    task automatic test_backpressure();
        apply_cfg(RESET_CFG);
        idle_en = 1'b0;
        @(posedge i_clk);
        rx_hold_req = 80;
        @(negedge i_clk);
        repeat (8) send_byte(1'($urandom), 8'($urandom), 1'b1);
        send_full(1'b0, 1'b1, 32'd42, 1'b0);
        wait_idle();
        idle_en = 1'b1;
    endtask

    // Random settings per phase; every third phase runs without idling
    task automatic test_random_traffic();
        int unsigned bytes_from;
        int unsigned phase_end;
        int unsigned phase;
        bytes_from = bytes_in;
        phase      = 0;
        while (bytes_in - bytes_from < RANDOM_BYTES) begin
            apply_cfg(rand_cfg());
            idle_en   = (phase % 3 != 2);
            phase_end = bytes_in + PHASE_BYTES;
            while (bytes_in < phase_end) random_window();
            wait_idle();
            phase++;
        end
    endtask

    // Closing stretch at full rate, no idling on either side
    task automatic test_final_stretch();
        idle_en = 1'b0;
        apply_cfg(rand_cfg());
        repeat (3) random_window();
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_page      = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        i_ready     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = dprv_pkg::CFG_MAGIC;
        i_cfg_data  = '0;
        idle_en     = 1'b1;
        rx_hold_req = 0;
        last_seq    = '0;
        regs_now    = RESET_CFG;
        clear_parse();
        page_fmt[0] = dprv_pkg::FMT_INVALID;
        page_fmt[1] = dprv_pkg::FMT_INVALID;
        page_seq[0] = '0;
        page_seq[1] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_sequence_compare();
        test_window_limits();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        test_final_stretch();

        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: dual_page_record_validator.f
rtl/dprv_pkg.sv
rtl/dual_page_record_validator.sv
bench/dual_page_record_validator_tb.sv
